// ----- rtl/alm_pkg.sv -----
package alm_pkg;

    // Default node count of the store.
    localparam int NODES_DEF = 16;

    // Fixed field widths.
    localparam int VALUE_W  = 32;
    localparam int SLOT_W   = 4;
    localparam int STATUS_W = 2;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED     = 2'd0,
        ST_FULL      = 2'd1,
        ST_REMOVED   = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // Request codes.
    typedef enum logic {
        REQ_ADD    = 1'b0,
        REQ_REMOVE = 1'b1
    } t_req;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_RD,
        S_ADD_WR,
        S_RM_CMP,
        S_RM_UNLINK,
        S_RM_FREE,
        S_RESP
    } t_state;

    // Strobes from the sequencer to the node store.
    typedef struct packed {
        logic rd_en;
        logic val_we;
        logic nxt_we;
        logic prv_we;
    } t_mem_ctl;

endpackage

// ----- rtl/alm_store.sv -----
module alm_store
    import alm_pkg::*;
#(
    parameter int NODES = NODES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_mem_ctl                      i_ctl,
    input  logic [$clog2(NODES)-1:0]      i_raddr,
    input  logic [$clog2(NODES)-1:0]      i_val_waddr,
    input  logic [VALUE_W-1:0]            i_val_wdata,
    input  logic [$clog2(NODES)-1:0]      i_nxt_waddr,
    input  logic [$clog2(NODES+1)-1:0]    i_nxt_wdata,
    input  logic [$clog2(NODES)-1:0]      i_prv_waddr,
    input  logic [$clog2(NODES+1)-1:0]    i_prv_wdata,
    output logic [VALUE_W-1:0]            o_rd_value,
    output logic [$clog2(NODES+1)-1:0]    o_rd_next,
    output logic [$clog2(NODES+1)-1:0]    o_rd_prev
);

    localparam int LW = $clog2(NODES + 1);

    logic [VALUE_W-1:0] r_val_mem [NODES];
    logic [LW-1:0]      r_nxt_mem [NODES];
    logic [LW-1:0]      r_prv_mem [NODES];

    logic [VALUE_W-1:0] r_rd_value;
    logic [LW-1:0]      r_rd_next;
    logic [LW-1:0]      r_rd_prev;
    logic [LW-1:0]      r_rd_addr;
    logic               r_untouched;
    logic [LW-1:0]      r_fill;

    // Write ports, one per memory.
    always_ff @(posedge i_clk) begin
        if (i_ctl.val_we) begin
            r_val_mem[i_val_waddr] <= i_val_wdata;
        end
        if (i_ctl.nxt_we) begin
            r_nxt_mem[i_nxt_waddr] <= i_nxt_wdata;
        end
        if (i_ctl.prv_we) begin
            r_prv_mem[i_prv_waddr] <= i_prv_wdata;
        end
    end

    // Shared registered read port. Entries at or above the fill count are treated as
    // unwritten since reset, so their next link reads as index + 1, the reset chain.
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_value  <= r_val_mem[i_raddr];
            r_rd_next   <= r_nxt_mem[i_raddr];
            r_rd_prev   <= r_prv_mem[i_raddr];
            r_rd_addr   <= LW'(i_raddr);
            r_untouched <= (LW'(i_raddr) >= r_fill);
        end
    end

    // Fill count: nodes leave the untouched region in index order.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_ctl.nxt_we && (LW'(i_nxt_waddr) >= r_fill)) begin
            r_fill <= LW'(i_nxt_waddr) + LW'(1);
        end
    end

    assign o_rd_value = r_rd_value;
    assign o_rd_next  = r_untouched ? (r_rd_addr + LW'(1)) : r_rd_next;
    assign o_rd_prev  = r_rd_prev;

endmodule

// ----- rtl/alm_seq.sv -----
module alm_seq
    import alm_pkg::*;
#(
    parameter int NODES = NODES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_req_type,
    input  logic [VALUE_W-1:0]            i_value,
    output logic                          o_busy,
    output logic                          o_done,
    output logic [STATUS_W-1:0]           o_status,
    output logic [SLOT_W-1:0]             o_slot,
    output logic                          o_list_empty,
    output t_mem_ctl                      o_ctl,
    output logic [$clog2(NODES)-1:0]      o_raddr,
    output logic [$clog2(NODES)-1:0]      o_val_waddr,
    output logic [VALUE_W-1:0]            o_val_wdata,
    output logic [$clog2(NODES)-1:0]      o_nxt_waddr,
    output logic [$clog2(NODES+1)-1:0]    o_nxt_wdata,
    output logic [$clog2(NODES)-1:0]      o_prv_waddr,
    output logic [$clog2(NODES+1)-1:0]    o_prv_wdata,
    input  logic [VALUE_W-1:0]            i_rd_value,
    input  logic [$clog2(NODES+1)-1:0]    i_rd_next,
    input  logic [$clog2(NODES+1)-1:0]    i_rd_prev
);

    localparam int IW = $clog2(NODES);
    localparam int LW = $clog2(NODES + 1);
    localparam logic [LW-1:0] NIL = LW'(NODES);

    t_state             r_state;
    t_state             n_state;
    logic [LW-1:0]      r_head;
    logic [LW-1:0]      r_tail;
    logic [LW-1:0]      r_free;
    logic               r_done;
    logic [VALUE_W-1:0] r_value;
    logic [LW-1:0]      r_p;
    logic [LW-1:0]      r_nx;
    logic [LW-1:0]      r_pv;
    logic [LW-1:0]      r_steps;
    t_status            r_status;
    t_status            r_o_status;
    logic [SLOT_W-1:0]  r_o_slot;
    logic               r_o_empty;

    logic               w_accept;
    logic               w_hit;
    logic               w_walk_end;

    function automatic logic f_is_node(input logic [LW-1:0] x);
        return (x < LW'(NODES));
    endfunction

    // Shared compare unit: one value compare and the walk bound per step.
    assign w_accept   = i_start && (r_state == S_IDLE);
    assign w_hit      = (i_rd_value == r_value);
    assign w_walk_end = !f_is_node(i_rd_next) || ((r_steps + LW'(1)) >= LW'(NODES));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_req_type == REQ_ADD) begin
                        n_state = f_is_node(r_free) ? S_ADD_RD : S_RESP;
                    end else begin
                        n_state = f_is_node(r_head) ? S_RM_CMP : S_RESP;
                    end
                end
            end
            S_ADD_RD:    n_state = S_ADD_WR;
            S_ADD_WR:    n_state = S_RESP;
            S_RM_CMP: begin
                if (w_hit) begin
                    n_state = S_RM_UNLINK;
                end else if (w_walk_end) begin
                    n_state = S_RESP;
                end
            end
            S_RM_UNLINK: n_state = S_RM_FREE;
            S_RM_FREE:   n_state = S_RESP;
            S_RESP:      n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // Store commands for each state.
    always_comb begin
        o_ctl       = '0;
        o_raddr     = '0;
        o_val_waddr = r_p[IW-1:0];
        o_val_wdata = r_value;
        o_nxt_waddr = r_p[IW-1:0];
        o_nxt_wdata = r_head;
        o_prv_waddr = r_p[IW-1:0];
        o_prv_wdata = NIL;
        unique case (r_state)
            S_IDLE: begin
                o_ctl.rd_en = w_accept;
                o_raddr     = (i_req_type == REQ_ADD) ? r_free[IW-1:0] : r_head[IW-1:0];
            end
            S_ADD_RD: begin
                o_ctl.val_we = 1'b1;
                o_ctl.nxt_we = 1'b1;
                o_ctl.prv_we = 1'b1;
            end
            S_ADD_WR: begin
                o_ctl.prv_we = f_is_node(r_head);
                o_prv_waddr  = r_head[IW-1:0];
                o_prv_wdata  = r_p;
            end
            S_RM_CMP: begin
                o_ctl.rd_en = !w_hit && !w_walk_end;
                o_raddr     = i_rd_next[IW-1:0];
            end
            S_RM_UNLINK: begin
                o_ctl.nxt_we = (r_p != r_head) && f_is_node(r_pv);
                o_nxt_waddr  = r_pv[IW-1:0];
                o_nxt_wdata  = r_nx;
                o_ctl.prv_we = (r_p != r_tail) && f_is_node(r_nx);
                o_prv_waddr  = r_nx[IW-1:0];
                o_prv_wdata  = r_pv;
            end
            S_RM_FREE: begin
                o_ctl.nxt_we = 1'b1;
                o_nxt_wdata  = r_free;
                o_ctl.prv_we = 1'b1;
            end
            S_RESP: begin
                o_ctl = '0;
            end
            default: begin
                o_ctl = '0;
            end
        endcase
    end

    // List pointers and sequencer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= NIL;
            r_tail  <= NIL;
            r_free  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_RESP);
            unique case (r_state)
                S_ADD_RD: begin
                    r_free <= i_rd_next;
                end
                S_ADD_WR: begin
                    if (!f_is_node(r_head)) begin
                        r_tail <= r_p;
                    end
                    r_head <= r_p;
                end
                S_RM_UNLINK: begin
                    if (r_p == r_head) begin
                        r_head <= f_is_node(r_nx) ? r_nx : NIL;
                    end
                    if (r_p == r_tail) begin
                        r_tail <= f_is_node(r_pv) ? r_pv : NIL;
                    end
                end
                S_RM_FREE: begin
                    r_free <= r_p;
                end
                default: begin
                    r_free <= r_free;
                end
            endcase
        end
    end

    // Working registers of the current request and the result beat.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_value <= i_value;
                    r_steps <= '0;
                    if (i_req_type == REQ_ADD) begin
                        r_p      <= r_free;
                        r_status <= ST_FULL;
                    end else begin
                        r_p      <= r_head;
                        r_status <= ST_NOT_FOUND;
                    end
                end
            end
            S_ADD_WR: begin
                r_status <= ST_ADDED;
            end
            S_RM_CMP: begin
                if (w_hit) begin
                    r_nx <= i_rd_next;
                    r_pv <= i_rd_prev;
                end else begin
                    r_p     <= i_rd_next;
                    r_steps <= r_steps + LW'(1);
                end
            end
            S_RM_FREE: begin
                r_status <= ST_REMOVED;
            end
            S_RESP: begin
                r_o_status <= r_status;
                r_o_slot   <= ((r_status == ST_ADDED) || (r_status == ST_REMOVED))
                              ? SLOT_W'(r_p) : '0;
                r_o_empty  <= !f_is_node(r_head);
            end
            default: begin
                r_value <= r_value;
            end
        endcase
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_done       = r_done;
    assign o_status     = r_o_status;
    assign o_slot       = r_o_slot;
    assign o_list_empty = r_o_empty;

endmodule

// ----- rtl/array_linked_list_manager.sv -----
// Channel   Handshake            Ports
// -------   ------------------   ---------------------------------------
// request   start && !busy       i_req_type, i_value
// result    o_done (one cycle)   o_status, o_slot, o_list_empty
//
// An add passes S_ADD_RD and S_ADD_WR before S_RESP and the o_done beat; a full store
// goes straight to S_RESP. A remove reads nodes from the head, up to NODES of them, one
// read of the store each; a match passes S_RM_UNLINK and S_RM_FREE before S_RESP, a miss goes to S_RESP.
// busy falls in the cycle o_done rises, so the next request may be accepted then.
// Reset is synchronous and active low; it needs no clearing pass.
// The receiver cannot stall: each result beat is shown for one cycle only.
module array_linked_list_manager
    import alm_pkg::*;
#(
    parameter int NODES = NODES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  logic                  i_req_type,
    input  logic signed [VALUE_W-1:0] i_value,
    output logic                  busy,
    output logic                  o_done,
    output logic [STATUS_W-1:0]   o_status,
    output logic [SLOT_W-1:0]     o_slot,
    output logic                  o_list_empty
);

    localparam int IW = $clog2(NODES);
    localparam int LW = $clog2(NODES + 1);

    t_mem_ctl           w_ctl;
    logic [IW-1:0]      w_raddr;
    logic [IW-1:0]      w_val_waddr;
    logic [VALUE_W-1:0] w_val_wdata;
    logic [IW-1:0]      w_nxt_waddr;
    logic [LW-1:0]      w_nxt_wdata;
    logic [IW-1:0]      w_prv_waddr;
    logic [LW-1:0]      w_prv_wdata;
    logic [VALUE_W-1:0] w_rd_value;
    logic [LW-1:0]      w_rd_next;
    logic [LW-1:0]      w_rd_prev;

    // Request sequencer with the list pointers and compare unit.
    alm_seq #(
        .NODES (NODES)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_req_type   (i_req_type),
        .i_value      (i_value),
        .o_busy       (busy),
        .o_done       (o_done),
        .o_status     (o_status),
        .o_slot       (o_slot),
        .o_list_empty (o_list_empty),
        .o_ctl        (w_ctl),
        .o_raddr      (w_raddr),
        .o_val_waddr  (w_val_waddr),
        .o_val_wdata  (w_val_wdata),
        .o_nxt_waddr  (w_nxt_waddr),
        .o_nxt_wdata  (w_nxt_wdata),
        .o_prv_waddr  (w_prv_waddr),
        .o_prv_wdata  (w_prv_wdata),
        .i_rd_value   (w_rd_value),
        .i_rd_next    (w_rd_next),
        .i_rd_prev    (w_rd_prev)
    );

    // Node store: values and both link arrays.
    alm_store #(
        .NODES (NODES)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_raddr     (w_raddr),
        .i_val_waddr (w_val_waddr),
        .i_val_wdata (w_val_wdata),
        .i_nxt_waddr (w_nxt_waddr),
        .i_nxt_wdata (w_nxt_wdata),
        .i_prv_waddr (w_prv_waddr),
        .i_prv_wdata (w_prv_wdata),
        .o_rd_value  (w_rd_value),
        .o_rd_next   (w_rd_next),
        .o_rd_prev   (w_rd_prev)
    );

endmodule

// ----- rtl/alm_checker.sv -----
module alm_checker
    import alm_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  o_done,
    input logic [STATUS_W-1:0]   o_status,
    input logic [SLOT_W-1:0]     o_slot,
    input logic                  o_list_empty
);

    // An accepted request keeps the block busy in the next cycle.
    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy
    ) else $error("busy low right after an accepted request");

    // Result beats never come in adjacent cycles.
    a_done_single: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done
    ) else $error("result strobe held for two cycles");

    // A result beat ends the request, so the block is free again.
    a_idle_on_done: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy
    ) else $error("busy while a result beat is shown");

    // Rejected requests report slot zero.
    a_slot_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_done && ((o_status == ST_FULL) || (o_status == ST_NOT_FOUND))) |-> (o_slot == '0)
    ) else $error("nonzero slot on a full or not-found result");

    // After an add the list holds at least that node.
    a_add_not_empty: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_ADDED)) |-> !o_list_empty
    ) else $error("list reported empty after an add");

endmodule

bind array_linked_list_manager alm_checker u_alm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_done       (o_done),
    .o_status     (o_status),
    .o_slot       (o_slot),
    .o_list_empty (o_list_empty)
);
